FILE: rtl/core/ssfl_pkg.sv
// Shared types and constants for the swap slot free-list allocator.
// Holds transaction structs, status and kind codes, controller states.
// No dependencies.
package ssfl_pkg;

    localparam int SLOT_W        = 11;
    localparam int STATUS_W      = 2;
    localparam int SLOTS_DEFAULT = 1024;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_EXHAUSTED  = 2'd1,
        STATUS_BAD_RELEASE = 2'd2
    } status_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_out;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slots_used;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/core/swap_slot_free_list_allocator.sv
// Swap slot free-list allocator with bump pointer, top level.
// An accepted transaction is captured, then committed to the result register
// once it is free; no new transaction is accepted before that commit, set by
// the registered read of the link RAM at accept followed by the commit cycle.
// Reset: synchronous, active low; a clearing pass then zeroes the link RAM,
// one entry a cycle until all SLOTS entries are clear, with s_ready held low.
module swap_slot_free_list_allocator #(
    parameter int SLOTS = ssfl_pkg::SLOTS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssfl_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output ssfl_pkg::out_item_t m_payload
);
    import ssfl_pkg::*;

    // Command and status between the controller and the datapath
    cmd_t cmd;
    sts_t sts;

    // Controller: walks the clearing pass, accepts one transaction, then
    // holds in execute until the result register is free.
    ssfl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: the link RAM is read at the free head while the transaction
    // is captured, so the link is ready for the execute cycle. A release
    // writes the old head into the slot's link and makes the slot the head.
    ssfl_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // An accepted transaction keeps s_ready low in the following cycle
    a_no_back_to_back: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("input accepted in two consecutive cycles");

    // A commit only happens when the result register can take it
    a_no_overwrite: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready)
    ) else $error("result overwritten before it was taken");

    // An exhausted pool never hands out a slot
    a_exhausted_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_payload.status == STATUS_EXHAUSTED)) |-> (m_payload.slot_out == '0)
    ) else $error("slot handed out with pool exhausted");

    // No transaction is accepted while the clearing pass runs
    a_clear_blocks: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !s_ready
    ) else $error("input accepted during clearing pass");

endmodule

FILE: rtl/core/ssfl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ssfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ssfl_ctrl.sv
// Controller for the swap slot allocator: clearing pass, accept, execute.
// Depends on ssfl_pkg.
module ssfl_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ssfl_pkg::sts_t sts,
    output ssfl_pkg::cmd_t cmd
);
    import ssfl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the outcome
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/core/ssfl_datapath.sv
// Datapath for the swap slot allocator: head, high-water count, link RAM,
// item and result registers. Depends on ssfl_pkg and ssfl_ram.
module ssfl_datapath #(
    parameter int SLOTS = ssfl_pkg::SLOTS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ssfl_pkg::cmd_t      cmd,
    output ssfl_pkg::sts_t      sts,
    input  ssfl_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output ssfl_pkg::out_item_t m_payload
);
    import ssfl_pkg::*;

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int HEAD_RAW = $clog2(SLOTS + 2);
    localparam int HEAD_W   = (HEAD_RAW > SLOT_W) ? HEAD_RAW : SLOT_W;
    localparam int HW_W     = $clog2(SLOTS + 1);
    localparam int WIDE_W   = (HW_W > SLOT_W) ? HW_W : SLOT_W;

    logic [HEAD_W-1:0] head_reg, head_next;
    logic [HW_W-1:0]   hw_reg, hw_next;
    logic [IDX_W-1:0]  clr_cnt_reg;
    in_item_t          item_reg;
    logic              m_valid_reg;
    out_item_t         out_reg, out_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [HEAD_W-1:0] ram_wdata;
    logic [HEAD_W-1:0] link;
    logic [HEAD_W-1:0] head_dec;
    logic [HEAD_W-1:0] slot_wide;
    logic [HEAD_W-1:0] slot_dec;
    logic [WIDE_W-1:0] hw_wide;
    logic              head_ok;
    logic              slot_ok;
    logic              do_release;

    assign head_dec  = head_reg - HEAD_W'(1);
    assign slot_wide = HEAD_W'(item_reg.slot);
    assign slot_dec  = slot_wide - HEAD_W'(1);
    assign head_ok   = (head_reg != '0) && (head_reg <= HEAD_W'(SLOTS));
    assign slot_ok   = (slot_wide != '0) && (slot_wide <= HEAD_W'(SLOTS));

    ssfl_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.capture),
        .raddr (head_dec[IDX_W-1:0]),
        .rdata (link)
    );

    always_comb begin
        head_next  = head_reg;
        hw_next    = hw_reg;
        do_release = 1'b0;
        out_next.slot_out = '0;
        out_next.status   = STATUS_OK;
        if (item_reg.kind == KIND_REQUEST) begin
            if (item_reg.slot != '0) begin
                out_next.slot_out = item_reg.slot;
            end else if (!head_ok) begin
                out_next.status = STATUS_EXHAUSTED;
            end else begin
                out_next.slot_out = head_reg[SLOT_W-1:0];
                if (link != '0) begin
                    head_next = link;
                end else begin
                    // never freed: bump the pointer
                    head_next = head_reg + HEAD_W'(1);
                    if (hw_reg < HW_W'(SLOTS)) begin
                        hw_next = hw_reg + HW_W'(1);
                    end
                end
            end
        end else begin
            if (!slot_ok) begin
                out_next.status = STATUS_BAD_RELEASE;
            end else begin
                do_release = 1'b1;
                head_next  = slot_wide;
            end
        end
        hw_wide = WIDE_W'(hw_next);
        out_next.slots_used = hw_wide[SLOT_W-1:0];
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        if (cmd.clear_step) begin
            ram_we = 1'b1;
        end else if (cmd.commit && do_release) begin
            ram_we    = 1'b1;
            ram_waddr = slot_dec[IDX_W-1:0];
            ram_wdata = head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= HEAD_W'(1);
            hw_reg      <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.commit) begin
                head_reg    <= head_next;
                hw_reg      <= hw_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_payload;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == IDX_W'(SLOTS - 1));
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_payload      = out_reg;

endmodule
